// File: hdl/etr_pkg.sv
// shared types, constants and arithmetic helpers for the euler to rotation block
// no dependencies
package etr_pkg;

    localparam int ATAN_ENTRIES = 30;

    typedef logic signed [31:0] t_q30;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [33:0] t_cw;

    localparam t_cw CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [32:0] Q30_POS = 33'sd1073741824;
    localparam logic signed [32:0] Q30_NEG = -33'sd1073741824;
    localparam t_prod Q30_HALF = 64'sd536870912;

    // arctangent of 2^-i as binary angle, full turn is 2^32
    function automatic t_cw atan_turn(input int idx);
        t_cw v;
        case (idx)
            0: v = 34'sd536870912;
            1: v = 34'sd316933406;
            2: v = 34'sd167458907;
            3: v = 34'sd85004756;
            4: v = 34'sd42667331;
            5: v = 34'sd21354465;
            6: v = 34'sd10679838;
            7: v = 34'sd5340245;
            8: v = 34'sd2670163;
            9: v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            24: v = 34'sd41;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // signed 32 x 32 full product
    function automatic t_prod mul32(input t_q30 a, input t_q30 b);
        t_prod pa;
        t_prod pb;
        pa = 64'(a);
        pb = 64'(b);
        return pa * pb;
    endfunction

    // q2.30 product rounding, half up
    function automatic t_q30 qrnd(input t_prod p);
        t_prod s;
        s = p + Q30_HALF;
        return s[61:30];
    endfunction

    // clamp to plus or minus one in q2.30
    function automatic t_q30 clamp_unit(input logic signed [32:0] v);
        logic signed [32:0] c;
        if (v > Q30_POS) begin
            c = Q30_POS;
        end else if (v < Q30_NEG) begin
            c = Q30_NEG;
        end else begin
            c = v;
        end
        return c[31:0];
    endfunction

    // round a q18.46 accumulator to q16.16 and saturate
    function automatic t_q30 rate_sat(input t_prod acc);
        t_prod s;
        logic signed [33:0] v;
        t_q30 r;
        s = acc + Q30_HALF;
        v = s[63:30];
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/etr_cordic.sv
// pipelined rotation mode cordic giving sine and cosine of a binary angle
// depends on etr_pkg
module etr_cordic #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_angle,
    output logic          o_valid,
    output etr_pkg::t_q30 o_sin,
    output etr_pkg::t_q30 o_cos
);
    import etr_pkg::*;

    localparam int NST = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam logic [31:0] ANGLE_MASK = 32'hffffffff << (32 - ANGLE_BITS);

    t_cw  r_x [0:NST];
    t_cw  r_y [0:NST];
    t_cw  r_z [0:NST];
    logic r_flip [0:NST];
    logic r_vld [0:NST];
    logic [31:0] n_red;
    logic n_flip;
    t_cw n_xf;
    t_cw n_yf;
    t_q30 r_sin;
    t_q30 r_cos;
    logic r_ovld;

    // quadrant reduction into [-1/4, 1/4) turn
    always_comb begin
        n_red  = i_angle & ANGLE_MASK;
        n_flip = n_red[31] ^ n_red[30];
        if (n_flip) begin
            n_red[31] = ~n_red[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_x[0]    <= CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= 34'(signed'(n_red));
        r_flip[0] <= n_flip;
    end

    // one micro-rotation per register stage
    for (genvar i = 0; i < NST; i++) begin : g_stage
        t_cw n_dx;
        t_cw n_dy;
        assign n_dx = r_y[i] >>> i;
        assign n_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - n_dx;
                r_y[i+1] <= r_y[i] + n_dy;
                r_z[i+1] <= r_z[i] - atan_turn(i);
            end else begin
                r_x[i+1] <= r_x[i] + n_dx;
                r_y[i+1] <= r_y[i] - n_dy;
                r_z[i+1] <= r_z[i] + atan_turn(i);
            end
            r_flip[i+1] <= r_flip[i];
        end
    end

    // undo the half turn and clamp
    always_comb begin
        n_xf = r_flip[NST] ? -r_x[NST] : r_x[NST];
        n_yf = r_flip[NST] ? -r_y[NST] : r_y[NST];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[NST];
        end
        r_cos <= clamp_unit(33'(n_xf > 34'(Q30_POS) ? 34'(Q30_POS) : n_xf));
        r_sin <= clamp_unit(33'(n_yf > 34'(Q30_POS) ? 34'(Q30_POS) : n_yf));
    end

    assign o_valid = r_ovld;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// File: hdl/euler_to_rotation_and_body_rates.sv
// top level: zyx euler angles to rotation matrix and body rates
// depends on etr_pkg and etr_cordic
//
// usage: drive the three binary angles and three euler rates and pulse start.
// busy is always low, so a transaction is taken on every cycle start is high.
// each transaction produces one result, shown for a single cycle with o_valid
// high; the receiver cannot stall and must take it then.
// throughput one transaction per cycle. the delay from start to o_valid is
// set by the cordic pipes plus four product stages: two multiply levels,
// each followed by a rounding stage.
// reset clears all valid bits; transactions in flight are dropped and no
// result appears until a new start.
module euler_to_rotation_and_body_rates #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [31:0]   i_roll_angle,
    input  logic [31:0]   i_pitch_angle,
    input  logic [31:0]   i_yaw_angle,
    input  etr_pkg::t_q30 i_roll_rate,
    input  etr_pkg::t_q30 i_pitch_rate,
    input  etr_pkg::t_q30 i_yaw_rate,
    output logic          o_valid,
    output etr_pkg::t_q30 o_rot_00,
    output etr_pkg::t_q30 o_rot_01,
    output etr_pkg::t_q30 o_rot_02,
    output etr_pkg::t_q30 o_rot_10,
    output etr_pkg::t_q30 o_rot_11,
    output etr_pkg::t_q30 o_rot_12,
    output etr_pkg::t_q30 o_rot_20,
    output etr_pkg::t_q30 o_rot_21,
    output etr_pkg::t_q30 o_rot_22,
    output etr_pkg::t_q30 o_body_rate_x,
    output etr_pkg::t_q30 o_body_rate_y,
    output etr_pkg::t_q30 o_body_rate_z
);
    import etr_pkg::*;

    localparam int NST = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int CLAT = NST + 2;
    localparam int LAT = CLAT + 4;

    logic n_acc;
    logic v_r, v_p, v_y;
    t_q30 sr, cr, sp, cp, sy, cy;

    assign busy  = 1'b0;
    assign n_acc = start & ~busy;

    etr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_acc), .i_angle(i_roll_angle),
        .o_valid(v_r), .o_sin(sr), .o_cos(cr));
    etr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_acc), .i_angle(i_pitch_angle),
        .o_valid(v_p), .o_sin(sp), .o_cos(cp));
    etr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_acc), .i_angle(i_yaw_angle),
        .o_valid(v_y), .o_sin(sy), .o_cos(cy));

    // rates ride alongside the cordic pipes
    t_q30 r_wr_d [0:CLAT-1];
    t_q30 r_wp_d [0:CLAT-1];
    t_q30 r_wy_d [0:CLAT-1];

    always_ff @(posedge i_clk) begin
        r_wr_d[0] <= i_roll_rate;
        r_wp_d[0] <= i_pitch_rate;
        r_wy_d[0] <= i_yaw_rate;
        for (int k = 1; k < CLAT; k++) begin
            r_wr_d[k] <= r_wr_d[k-1];
            r_wp_d[k] <= r_wp_d[k-1];
            r_wy_d[k] <= r_wy_d[k-1];
        end
    end

    // stage a: first level products
    logic  r_va;
    t_prod r_a_spsr, r_a_spcr, r_a_srcp, r_a_crcp, r_a_cycp, r_a_sycr;
    t_prod r_a_sysr, r_a_sycp, r_a_cycr, r_a_cysr, r_a_spwy, r_a_crwp, r_a_srwp;
    t_q30  r_a_sp, r_a_sy, r_a_cy, r_a_wr, r_a_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= v_r & v_p & v_y;
        end
        r_a_spsr <= mul32(sp, sr);
        r_a_spcr <= mul32(sp, cr);
        r_a_srcp <= mul32(sr, cp);
        r_a_crcp <= mul32(cr, cp);
        r_a_cycp <= mul32(cy, cp);
        r_a_sycr <= mul32(sy, cr);
        r_a_sysr <= mul32(sy, sr);
        r_a_sycp <= mul32(sy, cp);
        r_a_cycr <= mul32(cy, cr);
        r_a_cysr <= mul32(cy, sr);
        r_a_spwy <= mul32(sp, r_wy_d[CLAT-1]);
        r_a_crwp <= mul32(cr, r_wp_d[CLAT-1]);
        r_a_srwp <= mul32(sr, r_wp_d[CLAT-1]);
        r_a_sp   <= sp;
        r_a_sy   <= sy;
        r_a_cy   <= cy;
        r_a_wr   <= r_wr_d[CLAT-1];
        r_a_wy   <= r_wy_d[CLAT-1];
    end

    // stage b: round first level products
    logic  r_vb;
    t_q30  r_b_spsr, r_b_spcr, r_b_srcp, r_b_crcp, r_b_cycp, r_b_sycr;
    t_q30  r_b_sysr, r_b_sycp, r_b_cycr, r_b_cysr;
    t_prod r_b_spwy, r_b_crwp, r_b_srwp;
    t_q30  r_b_sp, r_b_sy, r_b_cy, r_b_wr, r_b_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_b_spsr <= qrnd(r_a_spsr);
        r_b_spcr <= qrnd(r_a_spcr);
        r_b_srcp <= qrnd(r_a_srcp);
        r_b_crcp <= qrnd(r_a_crcp);
        r_b_cycp <= qrnd(r_a_cycp);
        r_b_sycr <= qrnd(r_a_sycr);
        r_b_sysr <= qrnd(r_a_sysr);
        r_b_sycp <= qrnd(r_a_sycp);
        r_b_cycr <= qrnd(r_a_cycr);
        r_b_cysr <= qrnd(r_a_cysr);
        r_b_spwy <= r_a_spwy;
        r_b_crwp <= r_a_crwp;
        r_b_srwp <= r_a_srwp;
        r_b_sp   <= r_a_sp;
        r_b_sy   <= r_a_sy;
        r_b_cy   <= r_a_cy;
        r_b_wr   <= r_a_wr;
        r_b_wy   <= r_a_wy;
    end

    // stage c: yaw factor and yaw rate products
    logic  r_vc;
    t_prod r_c_cyspsr, r_c_syspcr, r_c_syspsr, r_c_cyspcr, r_c_srcpwy, r_c_crcpwy;
    t_q30  r_c_cycp, r_c_sycr, r_c_sysr, r_c_sycp, r_c_cycr, r_c_cysr;
    t_q30  r_c_srcp, r_c_crcp, r_c_sp, r_c_wr;
    t_prod r_c_spwy, r_c_crwp, r_c_srwp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        r_c_cyspsr <= mul32(r_b_cy, r_b_spsr);
        r_c_syspcr <= mul32(r_b_sy, r_b_spcr);
        r_c_syspsr <= mul32(r_b_sy, r_b_spsr);
        r_c_cyspcr <= mul32(r_b_cy, r_b_spcr);
        r_c_srcpwy <= mul32(r_b_srcp, r_b_wy);
        r_c_crcpwy <= mul32(r_b_crcp, r_b_wy);
        r_c_cycp   <= r_b_cycp;
        r_c_sycr   <= r_b_sycr;
        r_c_sysr   <= r_b_sysr;
        r_c_sycp   <= r_b_sycp;
        r_c_cycr   <= r_b_cycr;
        r_c_cysr   <= r_b_cysr;
        r_c_srcp   <= r_b_srcp;
        r_c_crcp   <= r_b_crcp;
        r_c_sp     <= r_b_sp;
        r_c_wr     <= r_b_wr;
        r_c_spwy   <= r_b_spwy;
        r_c_crwp   <= r_b_crwp;
        r_c_srwp   <= r_b_srwp;
    end

    // stage d: sums, clamps and rate saturation
    logic  r_vd;
    t_q30  r_rot [0:8];
    t_q30  r_bx, r_by, r_bz;
    t_prod n_wr30;

    assign n_wr30 = t_prod'({{2{r_c_wr[31]}}, r_c_wr, 30'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vc;
        end
        r_rot[0] <= clamp_unit(33'(r_c_cycp));
        r_rot[1] <= clamp_unit(33'(qrnd(r_c_cyspsr)) - 33'(r_c_sycr));
        r_rot[2] <= clamp_unit(33'(r_c_sysr) + 33'(qrnd(r_c_cyspcr)));
        r_rot[3] <= clamp_unit(33'(r_c_sycp));
        r_rot[4] <= clamp_unit(33'(r_c_cycr) + 33'(qrnd(r_c_syspsr)));
        r_rot[5] <= clamp_unit(33'(qrnd(r_c_syspcr)) - 33'(r_c_cysr));
        r_rot[6] <= clamp_unit(-33'(r_c_sp));
        r_rot[7] <= clamp_unit(33'(r_c_srcp));
        r_rot[8] <= clamp_unit(33'(r_c_crcp));
        r_bx     <= rate_sat(n_wr30 - r_c_spwy);
        r_by     <= rate_sat(r_c_crwp + r_c_srcpwy);
        r_bz     <= rate_sat(r_c_crcpwy - r_c_srwp);
    end

    assign o_valid       = r_vd;
    assign o_rot_00      = r_rot[0];
    assign o_rot_01      = r_rot[1];
    assign o_rot_02      = r_rot[2];
    assign o_rot_10      = r_rot[3];
    assign o_rot_11      = r_rot[4];
    assign o_rot_12      = r_rot[5];
    assign o_rot_20      = r_rot[6];
    assign o_rot_21      = r_rot[7];
    assign o_rot_22      = r_rot[8];
    assign o_body_rate_x = r_bx;
    assign o_body_rate_y = r_by;
    assign o_body_rate_z = r_bz;

    // every result traces back to a transaction a fixed latency earlier
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching transaction");

    // the three cordic pipes stay in lockstep
    a_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_r == v_p) && (v_p == v_y))
        else $error("cordic pipes out of step");

    // matrix entries 00 and 22 of the diagonal stay within unity
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rot_00 <= 32'sd1073741824 && o_rot_00 >= -32'sd1073741824
                  && o_rot_22 <= 32'sd1073741824 && o_rot_22 >= -32'sd1073741824))
        else $error("matrix entry out of range");

endmodule
